// ===== src/dttm_pkg.sv =====
package dttm_pkg;

  localparam int YEAR_BITS_DEF = 24;
  localparam int YEAR_BITS_MAX = 32;
  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 16;

  localparam int PM_YEAR   = 0;
  localparam int PM_MONTH  = 1;
  localparam int PM_DAY    = 2;
  localparam int PM_HOUR   = 3;
  localparam int PM_MINUTE = 4;
  localparam int PM_SECOND = 5;
  localparam int PM_ZONE   = 6;

  localparam logic signed [31:0] DEFAULT_YEAR  = 32'sd1972;
  localparam logic [3:0]         DEFAULT_MONTH = 4'd12;

  // floor(2^36 / 25), quotient taken from product bits [63:36]
  localparam logic [31:0] RECIP25     = 32'd2748779069;
  localparam int          RECIP_SHIFT = 36;

  localparam logic signed [59:0] SEC_PER_YEAR = 60'sd31536000;
  localparam logic signed [59:0] SEC_PER_DAY  = 60'sd86400;
  localparam logic [16:0]        SEC_PER_HOUR = 17'd3600;
  localparam logic signed [18:0] SEC_PER_MIN  = 19'sd60;
  localparam logic [15:0]        MS_PER_SEC   = 16'd1000;
  localparam logic [15:0]        PACK_ABSENT  = 16'hffff;

  typedef struct packed {
    logic signed [32:0] y;
    logic [31:0]        y_abs;
    logic [3:0]         yp_lo;
    logic signed [9:0]  dbase;
    logic               adj_en;
    logic signed [18:0] tod;
    logic [9:0]         ms;
    logic [15:0]        packed_ms;
  } item_t;

  typedef struct packed {
    logic signed [59:0] timeline_ms;
    logic [15:0]        second_ms_packed;
  } result_t;

  function automatic logic [8:0] days_before(input logic [3:0] mo);
    logic [8:0] d;
    case (mo)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mo);
    logic [4:0] d;
    case (mo)
      4'd2:    d = 5'd28;
      4'd4:    d = 5'd30;
      4'd6:    d = 5'd30;
      4'd9:    d = 5'd30;
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ===== src/datetime_to_timeline_ms_core.sv =====
// Converts one XSD date-time request per cycle into its signed millisecond position on
// the time line (low 60 bits) and the packed second*1000+millisecond word. Absent fields
// take their defaults from the presence mask. Requests are decoded on entry into a 4-deep
// queue and run through a 7-stage arithmetic pipeline into a 16-entry result queue. Sustained
// rate is one request per cycle while results are popped; the back end issues only while
// the result queue has a free slot reserved, so with out_pop held low at most 16 results
// plus 4 queued requests are held.
module datetime_to_timeline_ms_core #(
  parameter int YEAR_BITS = dttm_pkg::YEAR_BITS_DEF,
  parameter int MID_DEPTH = dttm_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = dttm_pkg::OUT_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic signed [YEAR_BITS-1:0] in_year,
  input  logic [3:0]                  in_month,
  input  logic [4:0]                  in_day,
  input  logic [4:0]                  in_hour,
  input  logic [5:0]                  in_minute,
  input  logic [5:0]                  in_second,
  input  logic [9:0]                  in_millisecond,
  input  logic signed [10:0]          in_zone_offset_minutes,
  input  logic [6:0]                  in_present_mask,
  input  logic                        out_pop,
  output logic                        out_empty,
  output logic signed [59:0]          out_timeline_ms,
  output logic [15:0]                 out_second_ms_packed
);
  import dttm_pkg::*;

  item_t   front_item, mid_item;
  result_t back_res, out_res;
  logic    mid_empty, item_take, res_push, out_full_unused;

  dttm_front #(
    .YEAR_BITS(YEAR_BITS)
  ) u_front (
    .in_year                (in_year),
    .in_month               (in_month),
    .in_day                 (in_day),
    .in_hour                (in_hour),
    .in_minute              (in_minute),
    .in_second              (in_second),
    .in_millisecond         (in_millisecond),
    .in_zone_offset_minutes (in_zone_offset_minutes),
    .in_present_mask        (in_present_mask),
    .item                   (front_item)
  );

  dttm_fifo #(
    .W    ($bits(item_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_item),
    .full  (in_full),
    .pop   (item_take),
    .rdata (mid_item),
    .empty (mid_empty)
  );

  dttm_back #(
    .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (!mid_empty),
    .item       (mid_item),
    .item_take  (item_take),
    .res_popped (out_pop && !out_empty),
    .res_push   (res_push),
    .res        (back_res)
  );

  dttm_fifo #(
    .W    ($bits(result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (back_res),
    .full  (out_full_unused),
    .pop   (out_pop),
    .rdata (out_res),
    .empty (out_empty)
  );

  assign out_timeline_ms      = out_res.timeline_ms;
  assign out_second_ms_packed = out_res.second_ms_packed;

endmodule

// ===== src/dttm_fifo.sv =====
module dttm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== src/dttm_front.sv =====
module dttm_front #(
  parameter int YEAR_BITS = 24
) (
  input  logic signed [YEAR_BITS-1:0] in_year,
  input  logic [3:0]                  in_month,
  input  logic [4:0]                  in_day,
  input  logic [4:0]                  in_hour,
  input  logic [5:0]                  in_minute,
  input  logic [5:0]                  in_second,
  input  logic [9:0]                  in_millisecond,
  input  logic signed [10:0]          in_zone_offset_minutes,
  input  logic [6:0]                  in_present_mask,
  output dttm_pkg::item_t             item
);
  import dttm_pkg::*;

  logic signed [31:0] yp;
  logic signed [32:0] y;
  logic [3:0]         mo_raw, mo;
  logic [4:0]         dsel;
  logic [8:0]         db;
  logic [4:0]         hr;
  logic [5:0]         mi, se;
  logic [9:0]         ms;
  logic signed [10:0] tz;
  logic signed [11:0] mi_adj;
  logic [16:0]        hr_sec;
  logic signed [18:0] mi_sec;

  always_comb begin
    yp = in_present_mask[PM_YEAR] ? YEAR_BITS_MAX'(in_year) : DEFAULT_YEAR;
    y  = 33'(yp) - 33'sd1;

    mo_raw = in_present_mask[PM_MONTH] ? in_month : DEFAULT_MONTH;
    if (mo_raw == 4'd0) begin
      mo = 4'd1;
    end else if (mo_raw > 4'd12) begin
      mo = 4'd12;
    end else begin
      mo = mo_raw;
    end

    dsel = in_present_mask[PM_DAY] ? in_day : month_len(mo);
    db   = days_before(mo);

    hr = in_present_mask[PM_HOUR]   ? in_hour   : 5'd0;
    mi = in_present_mask[PM_MINUTE] ? in_minute : 6'd0;
    se = in_present_mask[PM_SECOND] ? in_second : 6'd0;
    ms = in_present_mask[PM_SECOND] ? in_millisecond : 10'd0;
    tz = in_present_mask[PM_ZONE]   ? in_zone_offset_minutes : 11'sd0;

    mi_adj = $signed({6'b0, mi}) - 12'(tz);
    hr_sec = 17'(hr) * SEC_PER_HOUR;
    mi_sec = 19'(mi_adj) * SEC_PER_MIN;

    item.y         = y;
    item.y_abs     = y[32] ? 32'(-y) : y[31:0];
    item.yp_lo     = yp[3:0];
    item.dbase     = $signed({5'b0, dsel}) + $signed({1'b0, db}) - 10'sd1;
    // leap day counts for months after february, and for a default day in february
    item.adj_en    = (mo > 4'd2) || ((mo == 4'd2) && !in_present_mask[PM_DAY]);
    item.tod       = $signed({2'b0, hr_sec}) + mi_sec + $signed({13'b0, se});
    item.ms        = ms;
    item.packed_ms = in_present_mask[PM_SECOND] ? (16'(se) * MS_PER_SEC + 16'(ms))
                                                : PACK_ABSENT;
  end

endmodule

// ===== src/dttm_back.sv =====
module dttm_back #(
  parameter int OUT_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  dttm_pkg::item_t   item,
  output logic              item_take,
  input  logic              res_popped,
  output logic              res_push,
  output dttm_pkg::result_t res
);
  import dttm_pkg::*;

  localparam int NS = 7;
  localparam int PW = $clog2(OUT_DEPTH) + 1;

  logic [PW-1:0] pend_r, pend_nxt;
  logic [NS-1:0] v_r, v_nxt;

  item_t              it_s1_r, it_s2_r;
  logic [63:0]        prod_s1_r, prod_s1_nxt;
  logic [27:0]        q25_s2_r, q25_s2_nxt;
  logic [4:0]         r25_s2_r, r25_s2_nxt;
  logic signed [32:0] days_s3_r, days_s3_nxt;
  logic signed [59:0] ysec_s3_r, ysec_s3_nxt;
  logic signed [18:0] tod_s3_r, tod_s4_r;
  logic [9:0]         ms_s3_r, ms_s4_r, ms_s5_r;
  logic [15:0]        pk_s3_r, pk_s4_r, pk_s5_r, pk_s6_r, pk_s7_r;
  logic signed [59:0] dsec_s4_r, dsec_s4_nxt;
  logic signed [59:0] ysec_s4_r;
  logic signed [59:0] sec_s5_r, sec_s5_nxt;
  logic [59:0]        a_s6_r, a_s6_nxt, b_s6_r, b_s6_nxt;
  logic [59:0]        tl_s7_r, tl_s7_nxt;

  logic [27:0] q0;
  logic [31:0] q0x25;
  logic [5:0]  r0;
  logic        fix;
  logic        neg, m4, m16, m25, lp;
  logic [30:0] t;
  logic signed [32:0] ts;

  assign item_take = item_valid && (pend_r < PW'(OUT_DEPTH));

  always_comb begin
    pend_nxt = pend_r + PW'(item_take) - PW'(res_popped);
    v_nxt    = {v_r[NS-2:0], item_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      v_r    <= '0;
    end else begin
      pend_r <= pend_nxt;
      v_r    <= v_nxt;
    end
  end

  // reciprocal divide by 25, then one correction step
  always_comb begin
    prod_s1_nxt = 64'(item.y_abs) * 64'(RECIP25);

    q0    = prod_s1_r[63:RECIP_SHIFT];
    q0x25 = 32'(q0) * 32'd25;
    r0    = 6'(it_s1_r.y_abs - q0x25);
    fix   = (r0 >= 6'd25);
    q25_s2_nxt = q0 + 28'(fix);
    r25_s2_nxt = fix ? 5'(r0 - 6'd25) : r0[4:0];
  end

  always_comb begin
    neg = it_s2_r.y[32];
    m4  = (it_s2_r.yp_lo[1:0] == 2'd0);
    m16 = (it_s2_r.yp_lo == 4'd0);
    m25 = neg ? (r25_s2_r == 5'd1) : (r25_s2_r == 5'd24);
    lp  = m4 && (!m25 || m16);
    t   = 31'(it_s2_r.y_abs >> 2) - 31'(q25_s2_r >> 2) + 31'(q25_s2_r >> 4);
    ts  = $signed({2'b0, t});
    days_s3_nxt = (neg ? -ts : ts) + 33'(it_s2_r.dbase)
                + $signed({32'b0, lp && it_s2_r.adj_en});
    ysec_s3_nxt = 60'(it_s2_r.y) * SEC_PER_YEAR;

    dsec_s4_nxt = 60'(days_s3_r) * SEC_PER_DAY;
    sec_s5_nxt  = ysec_s4_r + dsec_s4_r + 60'(tod_s4_r);

    // times 1000 as 1024 - 16 - 8
    a_s6_nxt  = (60'(sec_s5_r) << 10) - (60'(sec_s5_r) << 4);
    b_s6_nxt  = (60'(sec_s5_r) << 3) - 60'(ms_s5_r);
    tl_s7_nxt = a_s6_r - b_s6_r;
  end

  always_ff @(posedge clk) begin
    it_s1_r   <= item;
    prod_s1_r <= prod_s1_nxt;

    it_s2_r  <= it_s1_r;
    q25_s2_r <= q25_s2_nxt;
    r25_s2_r <= r25_s2_nxt;

    days_s3_r <= days_s3_nxt;
    ysec_s3_r <= ysec_s3_nxt;
    tod_s3_r  <= it_s2_r.tod;
    ms_s3_r   <= it_s2_r.ms;
    pk_s3_r   <= it_s2_r.packed_ms;

    dsec_s4_r <= dsec_s4_nxt;
    ysec_s4_r <= ysec_s3_r;
    tod_s4_r  <= tod_s3_r;
    ms_s4_r   <= ms_s3_r;
    pk_s4_r   <= pk_s3_r;

    sec_s5_r <= sec_s5_nxt;
    ms_s5_r  <= ms_s4_r;
    pk_s5_r  <= pk_s4_r;

    a_s6_r  <= a_s6_nxt;
    b_s6_r  <= b_s6_nxt;
    pk_s6_r <= pk_s5_r;

    tl_s7_r <= tl_s7_nxt;
    pk_s7_r <= pk_s6_r;
  end

  assign res_push             = v_r[NS-1];
  assign res.timeline_ms      = $signed(tl_s7_r);
  assign res.second_ms_packed = pk_s7_r;

endmodule
